FILE: rtl/m4xf_pkg.sv
// Shared constants and types for the 4x4 matrix transform engine.
`timescale 1ns / 1ps
`default_nettype none
package m4xf_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 4;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int DEPTH     = 16;

	localparam logic [1:0] CMD_LOAD_A    = 2'd0;
	localparam logic [1:0] CMD_LOAD_B    = 2'd1;
	localparam logic [1:0] CMD_COMPOSE   = 2'd2;
	localparam logic [1:0] CMD_TRANSFORM = 2'd3;

	localparam logic KIND_VEC  = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	localparam logic [IDX_W-1:0] ELEM_LAST = 4'd15;
	localparam logic [1:0]       LANE_LAST = 2'd3;

	localparam logic signed [DATA_W-1:0] Q_ONE   = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         addr;
		logic signed [DATA_W-1:0] data;
	} m4xf_wr_t;

	typedef struct packed {
		logic             first;
		logic             fin;
		logic [IDX_W-1:0] idx;
	} m4xf_tag_t;

	typedef struct packed {
		logic                     valid;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] value;
		logic                     ovf;
	} m4xf_dot_t;

endpackage
`default_nettype wire

FILE: rtl/mat4_transform_engine_top.sv
// Top level: command sequencer, vector latch and result registers.
//
//  channel   handshake            payload
//  command   start / busy         cmd, elem_index, elem_value, vec_x..vec_w
//  result    strobe (no stall)    kind, out_index, out_elem, res_x..res_w, last, overflow
//
// One signed 32x32 multiplier does every product, one per cycle, four per dot product.
// Loads finish in the accepting cycle and leave busy low.
// Transform: 16 products; the result strobe follows the last dot product.
// Compose: 64 products, one element strobe per dot product.
// Reset sets A to identity and B to zero; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module mat4_transform_engine_top
	import m4xf_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire        [1:0]          cmd,
	input  wire        [IDX_W-1:0]    elem_index,
	input  wire signed [DATA_W-1:0]   elem_value,
	input  wire signed [DATA_W-1:0]   vec_x,
	input  wire signed [DATA_W-1:0]   vec_y,
	input  wire signed [DATA_W-1:0]   vec_z,
	input  wire signed [DATA_W-1:0]   vec_w,
	output logic                      strobe,
	output logic                      kind,
	output logic       [IDX_W-1:0]    out_index,
	output logic signed [DATA_W-1:0]  out_elem,
	output logic signed [DATA_W-1:0]  res_x,
	output logic signed [DATA_W-1:0]  res_y,
	output logic signed [DATA_W-1:0]  res_z,
	output logic signed [DATA_W-1:0]  res_w,
	output logic                      last,
	output logic                      overflow
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0]               state_q;
	logic                     compose_q;
	logic [5:0]               cnt_q;
	logic signed [DATA_W-1:0] vec_q  [4];
	logic signed [DATA_W-1:0] vres_q [3];
	logic                     ovf_q;
	logic                     strobe_q;

	logic                     accept;
	logic                     issue;
	logic                     issue_end;
	logic [1:0]               k_cnt;
	logic [1:0]               r_cnt;
	logic [1:0]               c_cnt;
	m4xf_tag_t                tag;
	m4xf_wr_t                 load_a;
	m4xf_wr_t                 load_b;
	m4xf_wr_t                 comp_wr;
	logic                     flip;
	logic signed [DATA_W-1:0] a_rdata;
	logic signed [DATA_W-1:0] b_rdata;
	logic signed [DATA_W-1:0] b_op;
	m4xf_dot_t                dot;
	logic                     elem_done;
	logic                     vec_done;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	assign k_cnt = cnt_q[1:0];
	assign r_cnt = cnt_q[3:2];
	assign c_cnt = cnt_q[5:4];

	assign issue     = state_q == ST_ISSUE;
	assign issue_end = compose_q ? (cnt_q == 6'h3F) : (cnt_q[3:0] == 4'hF);

	assign tag.first = k_cnt == 2'd0;
	assign tag.fin   = k_cnt == LANE_LAST;
	assign tag.idx   = {c_cnt, r_cnt};

	assign load_a.we   = accept && (cmd == CMD_LOAD_A);
	assign load_a.addr = elem_index;
	assign load_a.data = elem_value;
	assign load_b.we   = accept && (cmd == CMD_LOAD_B);
	assign load_b.addr = elem_index;
	assign load_b.data = elem_value;

	assign elem_done    = dot.valid && compose_q;
	assign vec_done     = dot.valid && !compose_q && (dot.idx[1:0] == LANE_LAST);
	assign comp_wr.we   = elem_done;
	assign comp_wr.addr = dot.idx;
	assign comp_wr.data = dot.value;
	assign flip         = elem_done && (dot.idx == ELEM_LAST);

	assign b_op = compose_q ? b_rdata : vec_q[k_cnt];

	m4xf_mats u_mats (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_a  (load_a),
		.load_b  (load_b),
		.comp_wr (comp_wr),
		.flip    (flip),
		.a_raddr ({k_cnt, r_cnt}),
		.b_raddr ({c_cnt, k_cnt}),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata)
	);

	m4xf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.tag    (tag),
		.a_op   (a_rdata),
		.b_op   (b_op),
		.dot    (dot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			compose_q <= 1'b0;
			cnt_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= elem_done || vec_done;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_COMPOSE || cmd == CMD_TRANSFORM)) begin
						compose_q <= cmd == CMD_COMPOSE;
						cnt_q     <= '0;
						state_q   <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + 6'd1;
					if (issue_end) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (flip || vec_done) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_q[0] <= vec_x;
			vec_q[1] <= vec_y;
			vec_q[2] <= vec_z;
			vec_q[3] <= vec_w;
			ovf_q    <= 1'b0;
		end else if (dot.valid && !compose_q) begin
			ovf_q <= ovf_q || dot.ovf;
			if (dot.idx[1:0] != LANE_LAST) vres_q[dot.idx[1:0]] <= dot.value;
		end
		if (elem_done) begin
			kind      <= KIND_ELEM;
			out_index <= dot.idx;
			out_elem  <= dot.value;
			res_x     <= '0;
			res_y     <= '0;
			res_z     <= '0;
			res_w     <= '0;
			last      <= dot.idx == ELEM_LAST;
			overflow  <= dot.ovf;
		end else if (vec_done) begin
			kind      <= KIND_VEC;
			out_index <= '0;
			out_elem  <= '0;
			res_x     <= vres_q[0];
			res_y     <= vres_q[1];
			res_z     <= vres_q[2];
			res_w     <= dot.value;
			last      <= 1'b1;
			overflow  <= ovf_q || dot.ovf;
		end
	end

	assign strobe = strobe_q;

endmodule
`default_nettype wire

FILE: rtl/m4xf_mats.sv
// Matrix storage: two banks for A (active and compose target) and one for B.
`timescale 1ns / 1ps
`default_nettype none
module m4xf_mats
	import m4xf_pkg::*;
(
	input  wire                            clk,
	input  wire                            arst_n,
	input  m4xf_wr_t                       load_a,
	input  m4xf_wr_t                       load_b,
	input  m4xf_wr_t                       comp_wr,
	input  wire                            flip,
	input  wire        [IDX_W-1:0]         a_raddr,
	input  wire        [IDX_W-1:0]         b_raddr,
	output logic signed [DATA_W-1:0]       a_rdata,
	output logic signed [DATA_W-1:0]       b_rdata
);

	logic signed [DATA_W-1:0] bank0_q [DEPTH];
	logic signed [DATA_W-1:0] bank1_q [DEPTH];
	logic signed [DATA_W-1:0] mat_b_q [DEPTH];
	logic                     sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				bank0_q[i] <= (IDX_W'(i) >> 2) == (IDX_W'(i) & 4'd3) ? Q_ONE : '0;
				mat_b_q[i] <= '0;
			end
		end else begin
			if (load_a.we && !sel_q) bank0_q[load_a.addr] <= load_a.data;
			if (comp_wr.we &&  sel_q) bank0_q[comp_wr.addr] <= comp_wr.data;
			if (load_b.we) mat_b_q[load_b.addr] <= load_b.data;
			if (flip) sel_q <= ~sel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_a.we &&  sel_q) bank1_q[load_a.addr] <= load_a.data;
		if (comp_wr.we && !sel_q) bank1_q[comp_wr.addr] <= comp_wr.data;
	end

	assign a_rdata = sel_q ? bank1_q[a_raddr] : bank0_q[a_raddr];
	assign b_rdata = mat_b_q[b_raddr];

endmodule
`default_nettype wire

FILE: rtl/m4xf_mac.sv
// Shared multiply-accumulate unit with arithmetic shift and saturation.
`timescale 1ns / 1ps
`default_nettype none
module m4xf_mac
	import m4xf_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       issue,
	input  m4xf_tag_t                 tag,
	input  wire signed [DATA_W-1:0]   a_op,
	input  wire signed [DATA_W-1:0]   b_op,
	output m4xf_dot_t                 dot
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	m4xf_tag_t                tag_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-DATA_W:0]    upper;
	logic                     fits;
	logic                     vld_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic signed [DATA_W-1:0] val_s3;
	logic                     ovf_s3;

	assign prod = a_op * b_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && tag_s1.fin;
			vld_s3 <= vld_s2;
		end
	end

	assign shifted = acc_s2 >>> FRAC_BITS;
	assign upper   = shifted[ACC_W-1:DATA_W-1];
	assign fits    = (&upper) || !(|upper);

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		tag_s1  <= tag;
		if (vld_s1) begin
			acc_s2 <= tag_s1.first ? ACC_W'(prod_s1) : acc_s2 + ACC_W'(prod_s1);
			idx_s2 <= tag_s1.idx;
		end
		idx_s3 <= idx_s2;
		ovf_s3 <= !fits;
		if (fits) begin
			val_s3 <= shifted[DATA_W-1:0];
		end else begin
			val_s3 <= acc_s2[ACC_W-1] ? SAT_MIN : SAT_MAX;
		end
	end

	assign dot = {vld_s3, idx_s3, val_s3, ovf_s3};

endmodule
`default_nettype wire
